// ===== sv/uesc_pkg.sv =====
// Shared types, character codes and hex helpers for the escape-to-UTF-8 converter.
`timescale 1ns / 1ps

package uesc_pkg;

   localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
   localparam logic [7:0] U_CHAR         = 8'h75;
   localparam int         HOLD_DEPTH     = 5;
   localparam int         BURST_DEPTH    = 6;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] count_type;

   // Bytes caused by one input item, oldest in data[0].
   typedef struct packed {
      logic [BURST_DEPTH-1:0][7:0] data;
      count_type                   count;
      logic                        done;
   } burst_type;

   function automatic logic is_hex(input byte_type c);
      logic ok;
      ok = ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
      return ok;
   endfunction

   function automatic logic [3:0] hex_value(input byte_type c);
      logic [3:0] v;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         v = 4'(c - 8'h30);
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         v = 4'(c - 8'h37);
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         v = 4'(c - 8'h57);
      end else begin
         v = 4'h0;
      end
      return v;
   endfunction

endpackage

// ===== sv/uesc_decode.sv =====
// Escape decoder: held candidate bytes and the result bytes of one input item.
`timescale 1ns / 1ps

module uesc_decode (
   input  logic                clock,
   input  logic                reset,
   input  uesc_pkg::byte_type  in_byte,
   input  logic                end_of_text,
   input  logic                advance,
   output uesc_pkg::burst_type burst
);
   import uesc_pkg::*;

   byte_type   held_bytes_ff [HOLD_DEPTH];
   count_type  held_count_ff;
   count_type  held_count_in;

   logic       is_bs;
   logic       extend;
   logic       complete;
   logic       fresh;
   logic       emit_byte;
   count_type  flush_count;
   logic [15:0] code_point;
   count_type  utf8_len;

   always_comb begin
      is_bs    = (in_byte == BACKSLASH_CHAR);
      extend   = ((held_count_ff == 3'd1) && (in_byte == U_CHAR)) ||
                 ((held_count_ff >= 3'd2) && (held_count_ff <= 3'd4) && is_hex(in_byte));
      complete = (held_count_ff == 3'(HOLD_DEPTH)) && is_hex(in_byte);
      fresh    = !extend && !complete;

      flush_count = (fresh || (extend && end_of_text)) ? held_count_ff : 3'd0;
      if (extend) begin
         emit_byte = end_of_text;
      end else if (fresh) begin
         emit_byte = !is_bs || end_of_text;
      end else begin
         emit_byte = 1'b0;
      end

      code_point = {hex_value(held_bytes_ff[2]), hex_value(held_bytes_ff[3]),
                    hex_value(held_bytes_ff[4]), hex_value(in_byte)};
      if (code_point[15:7] == 9'd0) begin
         utf8_len = 3'd1;
      end else if (code_point[15:11] == 5'd0) begin
         utf8_len = 3'd2;
      end else begin
         utf8_len = 3'd3;
      end

      // Held bytes first, then the new byte; slots past the count are unused.
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         burst.data[i] = (3'(i) < flush_count) ? held_bytes_ff[i] : in_byte;
      end
      burst.data[BURST_DEPTH-1] = in_byte;
      burst.count = 3'(flush_count + {2'b00, emit_byte});
      burst.done  = end_of_text;

      if (complete) begin
         burst.count = utf8_len;
         case (utf8_len)
            3'd1: begin
               burst.data[0] = code_point[7:0];
            end
            3'd2: begin
               burst.data[0] = {3'b110, code_point[10:6]};
               burst.data[1] = {2'b10, code_point[5:0]};
            end
            default: begin
               burst.data[0] = {4'b1110, code_point[15:12]};
               burst.data[1] = {2'b10, code_point[11:6]};
               burst.data[2] = {2'b10, code_point[5:0]};
            end
         endcase
      end

      if (extend && !end_of_text) begin
         held_count_in = 3'(held_count_ff + 3'd1);
      end else if (fresh && is_bs && !end_of_text) begin
         held_count_in = 3'd1;
      end else begin
         held_count_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 3'd0;
      end else if (advance) begin
         held_count_ff <= held_count_in;
      end
   end

   // Candidate bytes carry no reset; only entries below the count are read.
   always_ff @(posedge clock) begin
      if (advance) begin
         if (extend) begin
            held_bytes_ff[held_count_ff] <= in_byte;
         end else if (fresh && is_bs) begin
            held_bytes_ff[0] <= in_byte;
         end
      end
   end

endmodule

// ===== sv/uesc_burst.sv =====
// Result register: holds the bytes of one item and shifts them out one per transfer.
`timescale 1ns / 1ps

module uesc_burst (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  uesc_pkg::burst_type load_burst,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output uesc_pkg::byte_type  rsp_out_byte,
   output logic                rsp_run_last,
   output logic                rsp_text_done,
   output logic                free
);
   import uesc_pkg::*;

   burst_type burst_ff;
   burst_type burst_in;

   always_comb begin
      rsp_valid     = (burst_ff.count != 3'd0);
      rsp_out_byte  = burst_ff.data[0];
      rsp_run_last  = (burst_ff.count == 3'd1);
      rsp_text_done = (burst_ff.count == 3'd1) && burst_ff.done;
      free          = !rsp_valid || (rsp_run_last && rsp_ready);

      burst_in = burst_ff;
      if (load) begin
         burst_in = load_burst;
      end else if (rsp_valid && rsp_ready) begin
         burst_in.data  = burst_ff.data >> 8;
         burst_in.count = 3'(burst_ff.count - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff.count <= 3'd0;
      end else begin
         burst_ff.count <= burst_in.count;
      end
      burst_ff.data <= burst_in.data;
      burst_ff.done <= burst_in.done;
   end

endmodule

// ===== sv/unicode_escape_to_utf8.sv =====
// Top level: rewrites backslash-u hex escapes in a byte stream as UTF-8.
//
//   channel | ports                                       | carries
//   --------+---------------------------------------------+-----------------------------
//   req     | req_valid req_ready req_in_byte             | one text byte per transfer,
//           | req_end_of_text                             | flag on the last byte
//   rsp     | rsp_valid rsp_ready rsp_out_byte            | one converted byte per
//           | rsp_run_last rsp_text_done                  | transfer, with item/text marks
//
// Flow: an accepted byte sits in the input register, is decoded there and
// moves on into the result register, whose bytes drive the output. Bytes
// that only extend an escape produce nothing and advance every cycle. An
// item with k result bytes occupies the result register until all k are
// taken, so a following item that produces output waits with req_ready low
// until the last of them transfers: the output port moves one byte per
// cycle while rsp_ready is high, so the input port keeps one byte per cycle
// only while items yield at most one result byte each.
// Reset clears the input valid, the escape count and the result count.
// Stalls: rsp_ready low holds the result register, which holds an input
// byte that produces output in the input register, which drops req_ready.
`timescale 1ns / 1ps

module unicode_escape_to_utf8 (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  uesc_pkg::byte_type req_in_byte,
   input  logic               req_end_of_text,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output uesc_pkg::byte_type rsp_out_byte,
   output logic               rsp_run_last,
   output logic               rsp_text_done
);
   import uesc_pkg::*;

   // Input register.
   logic      in_valid_ff;
   logic      in_valid_in;
   byte_type  in_byte_ff;
   logic      in_eot_ff;

   burst_type dec_burst;
   logic      burst_free;
   logic      advance;
   logic      load;

   // Advance when the item yields nothing or the result register frees up.
   assign advance = in_valid_ff && ((dec_burst.count == 3'd0) || burst_free);
   assign load    = advance && (dec_burst.count != 3'd0);

   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   uesc_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_byte     (in_byte_ff),
      .end_of_text (in_eot_ff),
      .advance     (advance),
      .burst       (dec_burst)
   );

   uesc_burst u_burst (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .load_burst    (dec_burst),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_text_done (rsp_text_done),
      .free          (burst_free)
   );

endmodule

// ===== sv/uesc_checker.sv =====
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps

module uesc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input uesc_pkg::byte_type req_in_byte,
   input logic               req_end_of_text,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input uesc_pkg::byte_type rsp_out_byte,
   input logic               rsp_run_last,
   input logic               rsp_text_done
);

   // A stalled result holds its byte and marks.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_run_last) && $stable(rsp_text_done))
      else $error("result changed while stalled");

   // The end of the text closes the run of its item.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_done |-> rsp_run_last)
      else $error("text_done without run_last");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With the pipeline empty after reset the input side is open.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

endmodule

bind unicode_escape_to_utf8 uesc_checker u_checker (.*);
